// ===== hdl/hsvrgb_pkg.sv =====
// Package: shared types, constants and fixed-point helpers for the HSV to RGB pixel unit
`timescale 1ns / 1ps
package hsvrgb_pkg;

    localparam int HUE_FRAC_BITS     = 4;
    localparam int CHANNEL_FRAC_BITS = 12;

    localparam int HUE_W   = 16;
    localparam int CH_W    = CHANNEL_FRAC_BITS + 1;
    localparam int BYTE_W  = 8;
    localparam int HM_W    = 13;
    localparam int SEC_W   = 3;
    localparam int REM_W   = 10;
    localparam int UHUE_W  = 17;

    localparam int CH_ONE      = 1 << CHANNEL_FRAC_BITS;
    localparam int CH_HALF     = 1 << (CHANNEL_FRAC_BITS - 1);
    localparam int HUE_CIRCLE  = 360 << HUE_FRAC_BITS;
    localparam int HUE_SECTOR  = 60 << HUE_FRAC_BITS;
    // offset that lifts every signed hue to a positive value, a whole number of circles
    localparam int HUE_OFFSET  = 6 * HUE_CIRCLE;

    // circle = 128 * 45, sector = 64 * 15; reciprocals exact over the value ranges used
    localparam int CIRC_SHIFT  = 7;
    localparam int CIRC_RECIP  = 1457;
    localparam int SEC_SHIFT   = 6;
    localparam int SEC_RECIP   = 4370;
    localparam int RECIP_SHIFT = 16;

    // f = (128*rem + 15) / 30, reciprocal of 30 scaled by 2^24
    localparam int F_RECIP       = 559241;
    localparam int F_RECIP_W     = 20;
    localparam int F_RECIP_SHIFT = 24;
    localparam int F_NUM_W       = 17;
    localparam int F_NUM_BIAS    = 15;

    localparam int SQ_W    = 2 * CH_W - 1;
    localparam int GPROD_W = SQ_W + 8;
    localparam int GSHIFT  = 2 * CHANNEL_FRAC_BITS;
    localparam int BYTE_MAX = 255;

    typedef logic [CH_W-1:0]   ch_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [HM_W-1:0] hm;
        ch_t             sat;
        ch_t             val;
    } hsvrgb_item_t;

    function automatic ch_t qmul(input ch_t a, input ch_t b);
        logic [2*CH_W-1:0] prod;
        prod = (2*CH_W)'(a) * (2*CH_W)'(b) + (2*CH_W)'(CH_HALF);
        return prod[CHANNEL_FRAC_BITS +: CH_W];
    endfunction

endpackage

// ===== hdl/hsvrgb_front.sv =====
// Front stage: takes requests, clamps S and V, wraps hue into one circle
`timescale 1ns / 1ps
module hsvrgb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
    input  hsvrgb_pkg::ch_t                  saturation,
    input  hsvrgb_pkg::ch_t                  brightness,
    output logic                             item_valid,
    output hsvrgb_pkg::hsvrgb_item_t         item,
    input  logic                             queue_full
);
    import hsvrgb_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    hsvrgb_item_t          item_reg;
    logic                  ready;
    logic                  load;
    logic [UHUE_W-1:0]     hue_ofs;
    logic [CIRC_SHIFT+2:0] circ_hi;
    logic [20:0]           circ_prod;
    logic [3:0]            circ_q;
    logic [UHUE_W-1:0]     circ_base;
    logic [UHUE_W-1:0]     hm_wide;

    assign ready = !valid_reg || !queue_full;
    assign full  = !ready;
    assign load  = push && ready;

    assign hue_ofs   = UHUE_W'({{2{hue[HUE_W-1]}}, hue} + 18'(HUE_OFFSET));
    assign circ_hi   = hue_ofs[UHUE_W-1:CIRC_SHIFT];
    assign circ_prod = 21'(circ_hi) * 21'(CIRC_RECIP);
    assign circ_q    = circ_prod[RECIP_SHIFT +: 4];
    assign circ_base = UHUE_W'(circ_q) * UHUE_W'(HUE_CIRCLE);
    assign hm_wide   = hue_ofs - circ_base;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!queue_full)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.hm  <= hm_wide[HM_W-1:0];
            item_reg.sat <= (saturation > ch_t'(CH_ONE)) ? ch_t'(CH_ONE) : saturation;
            item_reg.val <= (brightness > ch_t'(CH_ONE)) ? ch_t'(CH_ONE) : brightness;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/hsvrgb_queue.sv =====
// Two-entry queue between the front stage and the back pipeline
`timescale 1ns / 1ps
module hsvrgb_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  hsvrgb_pkg::hsvrgb_item_t wr_data,
    output logic                     q_full,
    input  logic                     rd_en,
    output hsvrgb_pkg::hsvrgb_item_t rd_data,
    output logic                     q_empty
);
    import hsvrgb_pkg::*;

    hsvrgb_item_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_wr;
    logic         do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/hsvrgb_back.sv =====
// Back pipeline: sector split, p/q/t products, channel order, gamma bytes
`timescale 1ns / 1ps
module hsvrgb_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  hsvrgb_pkg::hsvrgb_item_t q_data,
    output logic                     q_rd,
    output logic                     empty,
    input  logic                     pop,
    output hsvrgb_pkg::ch_t          red_linear,
    output hsvrgb_pkg::ch_t          green_linear,
    output hsvrgb_pkg::ch_t          blue_linear,
    output hsvrgb_pkg::byte_t        red_byte,
    output hsvrgb_pkg::byte_t        green_byte,
    output hsvrgb_pkg::byte_t        blue_byte
);
    import hsvrgb_pkg::*;

    logic [6:1]      valid_reg;
    logic [6:1]      valid_next;
    logic            adv;

    // stage 1
    logic [SEC_W-1:0] s1_sector_reg;
    logic [REM_W-1:0] s1_rem_reg;
    ch_t              s1_sat_reg;
    ch_t              s1_val_reg;
    logic [6:0]       sec_hi;
    logic [18:0]      sec_prod;
    logic [SEC_W-1:0] sec_q;
    logic [HM_W-1:0]  sec_base;
    logic [HM_W-1:0]  rem_wide;

    // stage 2
    logic [SEC_W-1:0] s2_sector_reg;
    ch_t              s2_f_reg;
    ch_t              s2_sat_reg;
    ch_t              s2_val_reg;
    logic [F_NUM_W-1:0]             f_num;
    logic [F_NUM_W+F_RECIP_W-1:0]   f_prod;
    ch_t                            f_raw;

    // stage 3
    logic [SEC_W-1:0] s3_sector_reg;
    ch_t              s3_sf_reg;
    ch_t              s3_sg_reg;
    ch_t              s3_p_reg;
    ch_t              s3_val_reg;

    // stage 4
    ch_t              s4_r_reg;
    ch_t              s4_g_reg;
    ch_t              s4_b_reg;
    ch_t              q_val;
    ch_t              t_val;
    ch_t              r_sel;
    ch_t              g_sel;
    ch_t              b_sel;

    // stage 5
    ch_t              s5_r_reg;
    ch_t              s5_g_reg;
    ch_t              s5_b_reg;
    logic [SQ_W-1:0]  s5_rsq_reg;
    logic [SQ_W-1:0]  s5_gsq_reg;
    logic [SQ_W-1:0]  s5_bsq_reg;

    // stage 6
    ch_t              s6_r_reg;
    ch_t              s6_g_reg;
    ch_t              s6_b_reg;
    byte_t            s6_rb_reg;
    byte_t            s6_gb_reg;
    byte_t            s6_bb_reg;

    function automatic byte_t gamma_byte(input logic [SQ_W-1:0] sq);
        logic [GPROD_W-1:0] prod;
        logic [GPROD_W-GSHIFT-1:0] b;
        prod = {sq, 8'b0} - GPROD_W'(sq) + GPROD_W'(1 << (GSHIFT - 1));
        b    = prod[GPROD_W-1:GSHIFT];
        return (b > (GPROD_W-GSHIFT)'(BYTE_MAX)) ? byte_t'(BYTE_MAX) : b[BYTE_W-1:0];
    endfunction

    assign adv  = !valid_reg[6] || pop;
    assign q_rd = adv && !q_empty;

    assign sec_hi   = q_data.hm[HM_W-1:SEC_SHIFT];
    assign sec_prod = 19'(sec_hi) * 19'(SEC_RECIP);
    assign sec_q    = sec_prod[RECIP_SHIFT +: SEC_W];
    assign sec_base = HM_W'(sec_q) * HM_W'(HUE_SECTOR);
    assign rem_wide = q_data.hm - sec_base;

    assign f_num  = {s1_rem_reg, 7'b0} + F_NUM_W'(F_NUM_BIAS);
    assign f_prod = (F_NUM_W+F_RECIP_W)'(f_num) * (F_NUM_W+F_RECIP_W)'(F_RECIP);
    assign f_raw  = f_prod[F_RECIP_SHIFT +: CH_W];

    assign q_val = qmul(s3_val_reg, ch_t'(CH_ONE) - s3_sf_reg);
    assign t_val = qmul(s3_val_reg, ch_t'(CH_ONE) - s3_sg_reg);

    always_comb
    begin
        unique case (s3_sector_reg)
            3'd1:
            begin
                r_sel = q_val;      g_sel = s3_val_reg; b_sel = s3_p_reg;
            end
            3'd2:
            begin
                r_sel = s3_p_reg;   g_sel = s3_val_reg; b_sel = t_val;
            end
            3'd3:
            begin
                r_sel = s3_p_reg;   g_sel = q_val;      b_sel = s3_val_reg;
            end
            3'd4:
            begin
                r_sel = t_val;      g_sel = s3_p_reg;   b_sel = s3_val_reg;
            end
            3'd5:
            begin
                r_sel = s3_val_reg; g_sel = s3_p_reg;   b_sel = q_val;
            end
            default:
            begin
                r_sel = s3_val_reg; g_sel = t_val;      b_sel = s3_p_reg;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv)
        begin
            valid_next = {valid_reg[5:1], !q_empty};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sector_reg <= sec_q;
            s1_rem_reg    <= rem_wide[REM_W-1:0];
            s1_sat_reg    <= q_data.sat;
            s1_val_reg    <= q_data.val;

            s2_sector_reg <= s1_sector_reg;
            s2_f_reg      <= (f_raw > ch_t'(CH_ONE)) ? ch_t'(CH_ONE) : f_raw;
            s2_sat_reg    <= s1_sat_reg;
            s2_val_reg    <= s1_val_reg;

            s3_sector_reg <= s2_sector_reg;
            s3_sf_reg     <= qmul(s2_sat_reg, s2_f_reg);
            s3_sg_reg     <= qmul(s2_sat_reg, ch_t'(CH_ONE) - s2_f_reg);
            s3_p_reg      <= qmul(s2_val_reg, ch_t'(CH_ONE) - s2_sat_reg);
            s3_val_reg    <= s2_val_reg;

            s4_r_reg      <= r_sel;
            s4_g_reg      <= g_sel;
            s4_b_reg      <= b_sel;

            s5_r_reg      <= s4_r_reg;
            s5_g_reg      <= s4_g_reg;
            s5_b_reg      <= s4_b_reg;
            s5_rsq_reg    <= SQ_W'(SQ_W'(s4_r_reg) * SQ_W'(s4_r_reg));
            s5_gsq_reg    <= SQ_W'(SQ_W'(s4_g_reg) * SQ_W'(s4_g_reg));
            s5_bsq_reg    <= SQ_W'(SQ_W'(s4_b_reg) * SQ_W'(s4_b_reg));

            s6_r_reg      <= s5_r_reg;
            s6_g_reg      <= s5_g_reg;
            s6_b_reg      <= s5_b_reg;
            s6_rb_reg     <= gamma_byte(s5_rsq_reg);
            s6_gb_reg     <= gamma_byte(s5_gsq_reg);
            s6_bb_reg     <= gamma_byte(s5_bsq_reg);
        end
    end

    assign empty        = !valid_reg[6];
    assign red_linear   = s6_r_reg;
    assign green_linear = s6_g_reg;
    assign blue_linear  = s6_b_reg;
    assign red_byte     = s6_rb_reg;
    assign green_byte   = s6_gb_reg;
    assign blue_byte    = s6_bb_reg;

endmodule

// ===== hdl/hsv_to_rgb_led_pixel_unit.sv =====
// Top level: HSV to RGB pixel unit, front stage, decoupling queue and back pipeline
// A request accepted on push passes 1 front register, 1 queue entry and 6 back pipeline
// stages before it is shown on the result ports.
// Throughput: one request per cycle, sustained while pop keeps up.
// A stalled result stops the back pipeline; the queue and front register still absorb 3 requests.
// Reset (rst_n low, asynchronous) empties the queue and all stages; payload is not cleared.
`timescale 1ns / 1ps
module hsv_to_rgb_led_pixel_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
    input  hsvrgb_pkg::ch_t                     saturation,
    input  hsvrgb_pkg::ch_t                     brightness,
    output logic                                empty,
    input  logic                                pop,
    output hsvrgb_pkg::ch_t                     red_linear,
    output hsvrgb_pkg::ch_t                     green_linear,
    output hsvrgb_pkg::ch_t                     blue_linear,
    output hsvrgb_pkg::byte_t                   red_byte,
    output hsvrgb_pkg::byte_t                   green_byte,
    output hsvrgb_pkg::byte_t                   blue_byte
);
    import hsvrgb_pkg::*;

    logic         front_valid;
    hsvrgb_item_t front_item;
    logic         q_full;
    logic         q_empty;
    logic         q_rd;
    hsvrgb_item_t q_data;

    hsvrgb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .item_valid (front_valid),
        .item       (front_item),
        .queue_full (q_full)
    );

    hsvrgb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_item),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    hsvrgb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .q_rd         (q_rd),
        .empty        (empty),
        .pop          (pop),
        .red_linear   (red_linear),
        .green_linear (green_linear),
        .blue_linear  (blue_linear),
        .red_byte     (red_byte),
        .green_byte   (green_byte),
        .blue_byte    (blue_byte)
    );

endmodule

// ===== hdl/hsvrgb_checker.sv =====
// Checker: port-level assertions for the HSV to RGB pixel unit, with its bind
`timescale 1ns / 1ps
module hsvrgb_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
    input  hsvrgb_pkg::ch_t                     saturation,
    input  hsvrgb_pkg::ch_t                     brightness,
    input  logic                                empty,
    input  logic                                pop,
    input  hsvrgb_pkg::ch_t                     red_linear,
    input  hsvrgb_pkg::ch_t                     green_linear,
    input  hsvrgb_pkg::ch_t                     blue_linear,
    input  hsvrgb_pkg::byte_t                   red_byte,
    input  hsvrgb_pkg::byte_t                   green_byte,
    input  hsvrgb_pkg::byte_t                   blue_byte
);
    import hsvrgb_pkg::*;

    // waiting result holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(red_linear) && $stable(green_linear)
            && $stable(blue_linear) && $stable(red_byte) && $stable(green_byte)
            && $stable(blue_byte)))
        else $error("result changed while waiting");

    a_linear_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (red_linear <= ch_t'(CH_ONE) && green_linear <= ch_t'(CH_ONE)
            && blue_linear <= ch_t'(CH_ONE)))
        else $error("linear channel above one");

    a_gamma_full: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((red_linear != ch_t'(CH_ONE) || red_byte == byte_t'(BYTE_MAX))
            && (green_linear != ch_t'(CH_ONE) || green_byte == byte_t'(BYTE_MAX))
            && (blue_linear != ch_t'(CH_ONE) || blue_byte == byte_t'(BYTE_MAX))))
        else $error("full channel without full byte");

    a_gamma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((red_linear != '0 || red_byte == '0)
            && (green_linear != '0 || green_byte == '0)
            && (blue_linear != '0 || blue_byte == '0)))
        else $error("dark channel with nonzero byte");

    // input backs up only behind a stalled result
    a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full while no result is waiting");

endmodule

bind hsv_to_rgb_led_pixel_unit hsvrgb_checker u_hsvrgb_checker (.*);
